// ===== hw/rtl/two_pattern_binary_matcher_defines.svh =====
// Assertion macros for the two-pattern binary matcher.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef TWO_PATTERN_BINARY_MATCHER_DEFINES_SVH
`define TWO_PATTERN_BINARY_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define TPBM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpbm assertion failed");
`define TPBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpbm assertion failed");
`else
`define TPBM_ASSERT_IMPL(lbl, ante, cons)
`define TPBM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tpbm_pkg.sv =====
// Shared types and constants of the two-pattern binary matcher.
// No dependencies.
package tpbm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int PAT_BITS_W      = 64;
  localparam int PAT_LEN_W       = 7;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_A_BITS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_A_LEN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_B_BITS = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_B_LEN  = 2'd3;

  localparam logic [PAT_LEN_W-1:0] LEN_RESET = 7'd1;

  typedef struct packed {
    logic [PAT_BITS_W-1:0] bits;
    logic [PAT_LEN_W-1:0]  len;
  } tpbm_pat_t;

endpackage

// ===== hw/rtl/tpbm_cfg_regs.sv =====
// Configuration registers holding both patterns and their lengths.
// Depends on tpbm_pkg.
module tpbm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [tpbm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tpbm_pkg::PAT_BITS_W-1:0]  cfg_data,
  output tpbm_pkg::tpbm_pat_t              pat_a,
  output tpbm_pkg::tpbm_pat_t              pat_b
);
  import tpbm_pkg::*;

  tpbm_pat_t pat_a_r;
  tpbm_pat_t pat_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_a_r.bits <= '0;
      pat_a_r.len  <= LEN_RESET;
      pat_b_r.bits <= '0;
      pat_b_r.len  <= LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_A_BITS: pat_a_r.bits <= cfg_data;
        REG_A_LEN:  pat_a_r.len  <= cfg_data[PAT_LEN_W-1:0];
        REG_B_BITS: pat_b_r.bits <= cfg_data;
        REG_B_LEN:  pat_b_r.len  <= cfg_data[PAT_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pat_a = pat_a_r;
  assign pat_b = pat_b_r;

endmodule

// ===== hw/rtl/tpbm_match.sv =====
// Masked compare of the newest symbols against one pattern.
// Depends on tpbm_pkg.
module tpbm_match #(
  parameter int MAX_PATTERN = tpbm_pkg::MAX_PATTERN_DEF
) (
  input  tpbm_pkg::tpbm_pat_t             pat,
  input  logic [MAX_PATTERN-1:0]          hist,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] fill,
  output logic                            hit
);
  import tpbm_pkg::*;

  localparam logic [PAT_LEN_W-1:0] CAP = PAT_LEN_W'(MAX_PATTERN);

  logic [PAT_LEN_W-1:0]   eff_len;
  logic [MAX_PATTERN-1:0] mask;
  logic [MAX_PATTERN-1:0] diff;

  always_comb begin
    eff_len = (pat.len > CAP) ? CAP : pat.len;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mask[i] = (PAT_LEN_W'(i) < eff_len);
    end
    diff = (hist ^ pat.bits[MAX_PATTERN-1:0]) & mask;
    hit  = (eff_len != '0) && (PAT_LEN_W'(fill) >= eff_len) && (diff == '0);
  end

endmodule

// ===== hw/rtl/two_pattern_binary_matcher.sv =====
// Top level of the two-pattern binary matcher: stream ports, input register,
// history state and result register. Depends on tpbm_pkg, tpbm_cfg_regs,
// tpbm_match and the assertion macro header.
//
// One symbol per transaction, one result per symbol. A new symbol is taken
// every clock cycle while results are taken as they come; a result is
// presented once its symbol has waited in the input register and the
// history update and both pattern compares have fed the result register.
// A stalled result holds the input register, and the input stalls once
// both registers are full. Patterns must be configured only while the
// stream is idle; the block itself does not enforce it. Pattern lengths
// above MAX_PATTERN act as MAX_PATTERN, and a length of zero never matches.
`include "two_pattern_binary_matcher_defines.svh"
module two_pattern_binary_matcher #(
  parameter int MAX_PATTERN = tpbm_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [0] symbol
  input  logic                            in_tuser,  // [0] start_req
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata, // [0] hit_a [1] hit_b [2] seen_a [3] seen_b
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpbm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tpbm_pkg::PAT_BITS_W-1:0] cfg_data
);
  import tpbm_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(MAX_PATTERN);

  tpbm_pat_t pat_a;
  tpbm_pat_t pat_b;

  logic s1_valid_r;
  logic s1_sym_r;
  logic s1_start_r;
  logic out_valid_r;
  logic [3:0] out_data_r;

  logic [MAX_PATTERN-1:0] hist_r;
  logic [MAX_PATTERN-1:0] hist_nxt;
  logic [MAX_PATTERN-1:0] hist_base;
  logic [MAX_PATTERN:0]   hist_shl;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;
  logic [FILL_W-1:0]      fill_base;
  logic [1:0]             seen_r;
  logic [1:0]             seen_nxt;
  logic                   hit_a;
  logic                   hit_b;
  logic                   out_load_ok;
  logic                   s1_adv;

  assign cfg_ready = 1'b1;

  tpbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .pat_a     (pat_a),
    .pat_b     (pat_b)
  );

  assign out_load_ok = !out_valid_r || out_tready;
  assign s1_adv      = s1_valid_r && out_load_ok;
  assign in_tready   = !s1_valid_r || out_load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sym_r   <= in_tdata[0];
      s1_start_r <= in_tuser;
    end
  end

  always_comb begin
    hist_base = s1_start_r ? '0 : hist_r;
    hist_shl  = {hist_base, s1_sym_r};
    hist_nxt  = hist_shl[MAX_PATTERN-1:0];
    fill_base = s1_start_r ? '0 : fill_r;
    fill_nxt  = (fill_base == FILL_CAP) ? fill_base : fill_base + FILL_W'(1);
    seen_nxt  = (s1_start_r ? 2'b00 : seen_r) | {hit_b, hit_a};
  end

  tpbm_match #(.MAX_PATTERN(MAX_PATTERN)) u_match_a (
    .pat  (pat_a),
    .hist (hist_nxt),
    .fill (fill_nxt),
    .hit  (hit_a)
  );

  tpbm_match #(.MAX_PATTERN(MAX_PATTERN)) u_match_b (
    .pat  (pat_b),
    .hist (hist_nxt),
    .fill (fill_nxt),
    .hit  (hit_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      fill_r <= '0;
      seen_r <= 2'b00;
    end else if (s1_adv) begin
      hist_r <= hist_nxt;
      fill_r <= fill_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {seen_nxt, hit_b, hit_a};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

  `TPBM_ASSERT_IMPL(a_hit_a_sets_seen, out_valid_r && out_data_r[0], out_data_r[2])
  `TPBM_ASSERT_IMPL(a_hit_b_sets_seen, out_valid_r && out_data_r[1], out_data_r[3])
  `TPBM_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_r <= FILL_CAP)
  `TPBM_ASSERT_NEXT(a_start_restarts_fill, s1_adv && s1_start_r, fill_r == FILL_W'(1))
  `TPBM_ASSERT_NEXT(a_result_follows, s1_adv, out_valid_r)

endmodule

// ===== sim/two_pattern_binary_matcher_test.sv =====
// Self-checking testbench for the two-pattern binary matcher.
// Drives symbol streams under several pattern settings and idle mixes, and checks every
// result against a predictor of the history and match flags. Needs tpbm_pkg and the RTL.
module two_pattern_binary_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpbm_pkg::*;

  localparam int CAP = MAX_PATTERN_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic sym;
    logic start;
  } symbol_item_t;

  typedef struct packed {
    logic seen_b;
    logic seen_a;
    logic hit_b;
    logic hit_a;
  } match_flags_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [PAT_BITS_W-1:0] cfg_data = '0;

  symbol_item_t symbol_queue[$];
  match_flags_t predicted_flags[$];
  logic         in_taken = 1'b0;
  int           queued = 0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           holdoff_left = 0;

  tpbm_pat_t    pat_a = '{bits: '0, len: LEN_RESET};
  tpbm_pat_t    pat_b = '{bits: '0, len: LEN_RESET};
  logic [63:0]  history = '0;
  logic [6:0]   fill = '0;
  logic         seen_a = 1'b0;
  logic         seen_b = 1'b0;

  two_pattern_binary_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic pattern_ends(tpbm_pat_t p);
    logic [6:0]  l;
    logic [63:0] m;
    l = (p.len > CAP) ? 7'(CAP) : p.len;
    if (l == 0 || fill < l) return 1'b0;
    m = (l == 7'd64) ? '1 : ((64'd1 << l) - 64'd1);
    return (history & m) == (p.bits & m);
  endfunction

  function automatic match_flags_t scan_symbol(symbol_item_t it);
    match_flags_t r;
    if (it.start) begin
      history = '0;
      fill = '0;
      seen_a = 1'b0;
      seen_b = 1'b0;
    end
    history = {history[62:0], it.sym};
    if (fill < CAP) fill = fill + 7'd1;
    r.hit_a = pattern_ends(pat_a);
    r.hit_b = pattern_ends(pat_b);
    seen_a = seen_a | r.hit_a;
    seen_b = seen_b | r.hit_b;
    r.seen_a = seen_a;
    r.seen_b = seen_b;
    return r;
  endfunction

  // Sender: a presented transaction is held until it is taken.
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (symbol_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, symbol_queue[0].sym};
        in_tuser <= symbol_queue[0].start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_tready <= 1'b0;
      holdoff_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    match_flags_t got;
    match_flags_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) predicted_flags.push_back(scan_symbol(symbol_queue.pop_front()));
    if (rst_n && out_tvalid && out_tready) begin
      got = match_flags_t'(out_tdata[3:0]);
      if (predicted_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: hit_a=%b hit_b=%b seen_a=%b seen_b=%b",
                   got.hit_a, got.hit_b, got.seen_a, got.seen_b);
      end else begin
        want = predicted_flags.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: hit_a %b/%b hit_b %b/%b seen_a %b/%b seen_b %b/%b",
                      " (expected/actual)"}, want.hit_a, got.hit_a, want.hit_b, got.hit_b,
                     want.seen_a, got.seen_a, want.seen_b, got.seen_b);
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_pattern_binary_matcher verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (addr)
      REG_A_BITS: pat_a.bits = data;
      REG_A_LEN:  pat_a.len = data[6:0];
      REG_B_BITS: pat_b.bits = data;
      REG_B_LEN:  pat_b.len = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_patterns(input logic [63:0] a_bits, input logic [6:0] a_len,
                              input logic [63:0] b_bits, input logic [6:0] b_len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_A_BITS, a_bits);
    write_reg(REG_A_LEN, {junk[63:7], a_len});
    junk = {$urandom, $urandom};
    write_reg(REG_B_BITS, b_bits);
    write_reg(REG_B_LEN, {junk[63:7], b_len});
  endtask

  task automatic queue_symbol(input logic s, input logic st);
    symbol_queue.push_back('{sym: s, start: st});
    queued++;
  endtask

  task automatic queue_pattern(input tpbm_pat_t p);
    int l;
    l = (p.len > CAP) ? CAP : int'(p.len);
    if (l == 0) begin
      repeat ($urandom_range(1, 6)) queue_symbol(1'($urandom_range(1)), 1'b0);
    end else begin
      for (int k = l - 1; k >= 0; k--) queue_symbol(p.bits[k], $urandom_range(99) < 3);
    end
  endtask

  task automatic queue_random_stream(input int count);
    int target;
    int pick;
    target = queued + count;
    while (queued < target) begin
      pick = $urandom_range(99);
      if (pick < 35) queue_pattern(pat_a);
      else if (pick < 70) queue_pattern(pat_b);
      else
        repeat ($urandom_range(1, 6))
          queue_symbol(1'($urandom_range(1)), $urandom_range(99) < 4);
    end
  endtask

  task automatic wait_drained();
    while (symbol_queue.size() != 0 || predicted_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_len();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      4: return 7'($urandom_range(13, 63));
      default: return 7'($urandom_range(2, 10));
    endcase
  endfunction

  initial begin
    logic [63:0] a_bits;
    logic [63:0] b_bits;
    logic [6:0]  a_len;
    logic [6:0]  b_len;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both patterns are the single symbol 0 out of reset, so they are identical.
    queue_symbol(1'b0, 1'b1);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b0);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b1);
    wait_drained();

    // Pattern B lies at the tail of pattern A, and A has junk above its length.
    set_patterns(64'hFFFF_FFFF_FFFF_FFF5, 7'd3, 64'h0000_0000_0000_0001, 7'd2);
    queue_symbol(1'b1, 1'b1);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b0);
    queue_symbol(1'b1, 1'b0);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b0);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b1);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b0);
    wait_drained();

    // A zero-length pattern never matches, and an overlong one needs a full history.
    set_patterns(64'h0, 7'd0, 64'h0, 7'd127);
    queue_symbol(1'b0, 1'b1);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b1, 1'b0);
    queue_symbol(1'b0, 1'b0);
    queue_symbol(1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      a_bits = {$urandom, $urandom};
      a_len = pick_len();
      case ($urandom_range(3))
        0: begin b_bits = a_bits; b_len = a_len; end
        1: begin b_bits = a_bits; b_len = 7'($urandom_range(1, 8)); end
        default: begin b_bits = {$urandom, $urandom}; b_len = pick_len(); end
      endcase
      if (ph == 0) begin
        a_len = 7'd64;
        b_len = 7'd127;
      end else if (ph == 1) begin
        a_len = 7'd1;
        b_len = 7'd0;
      end else if (ph == 2) begin
        a_bits = '1;
        b_bits = '0;
      end
      set_patterns(a_bits, a_len, b_bits, b_len);
      if (ph == 4) holdoff_left = 150;
      queue_random_stream(48);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("two_pattern_binary_matcher verification clean");
    end else begin
      $display("two_pattern_binary_matcher verification failed");
    end
    $finish;
  end

endmodule
